// ----- src/sndsum_pkg.sv -----
// Package with shared constants and codes for the symmetric nearest-point distance sum block.
`default_nettype none
package sndsum_pkg;
	localparam int DEF_MAX_POINTS = 512;
	localparam int DEF_COORD_BITS = 20;
	localparam int PENALTY_W = 21;
	localparam int SUM_W = 30;
	localparam int TOT_W = 31;
	localparam int CNT_OUT_W = 10;
	localparam logic [PENALTY_W-1:0] PENALTY_RESET = 21'h1FFFFF;
	localparam logic [SUM_W-1:0] SUM_LIMIT = 30'h3FFFFFFF;
	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;
endpackage
`default_nettype wire

// ----- src/symmetric_nearest_point_distance_sum_top.sv -----
// Top level of the symmetric nearest-point distance sum block with its sequencer.
// A load transaction is taken while idle; a compute transaction walks every point of
// one set against every point of the other through one shared multiply-accumulate
// unit (one coordinate square per cycle) and a bit-serial root, in both directions;
// a point facing an empty set adds the penalty instead.
// Throughput: one load per cycle; no input is taken while a compute runs.
// Reset (arst_n low) clears counts, overflow flag, sequencer and output valid; the
// penalty register returns to its maximum. Point memories are not cleared.
`default_nettype none
module symmetric_nearest_point_distance_sum_top #(
	parameter int MAX_POINTS = sndsum_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = sndsum_pkg::DEF_COORD_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [sndsum_pkg::PENALTY_W-1:0] cfg_wr_data,
	input  wire logic s_tvalid,
	output logic s_tready,
	// tdata fields from bit 0: x_coord, y_coord, z_coord, zero fill.
	input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// tuser fields from bit 0: op.
	input  wire logic [1:0] s_tuser,
	output logic m_tvalid,
	input  wire logic m_tready,
	// tdata fields from bit 0: sum_a_to_b, sum_b_to_a, total_distance,
	// points_in_a, points_in_b, overflowed.
	output logic [111:0] m_tdata
);
	import sndsum_pkg::*;

	localparam int PW = 3*COORD_BITS;
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS+1);
	localparam int DW = COORD_BITS + 1;
	localparam int SQ_W = 2*DW + 2;
	localparam int RT_W = SQ_W / 2;
	localparam int SC_W = $clog2(RT_W+1);
	localparam int AD_W = (RT_W > PENALTY_W) ? RT_W : PENALTY_W;
	localparam int ACC_W = ((AD_W > SUM_W) ? AD_W : SUM_W) + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_RD = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_CMP = 3'd4;
	localparam logic [2:0] ST_SQRT = 3'd5;
	localparam logic [2:0] ST_ACC = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0] state_q;
	logic [PW-1:0] mem_a [MAX_POINTS];
	logic [PW-1:0] mem_b [MAX_POINTS];
	logic [PW-1:0] rd_a_q, rd_b_q;
	logic [CW-1:0] count_a_q, count_b_q, i_q, j_q;
	logic dropped_q, dir_q;
	logic [PENALTY_W-1:0] penalty_q;
	logic [1:0] k_q;
	logic [SQ_W-1:0] acc_q, best_q, val_q;
	logic [RT_W+1:0] rem_q;
	logic [RT_W-1:0] root_q;
	logic [SC_W-1:0] sc_q;
	logic [AD_W-1:0] add_q;
	logic [SUM_W-1:0] sum_q, sum_ab_q;
	logic out_valid_q;
	logic [111:0] out_data_q;

	logic in_acc;
	logic [CW-1:0] nfrom, nto;
	logic [AW-1:0] addr_a, addr_b;
	logic [PW-1:0] from_pt, to_pt;
	logic signed [COORD_BITS-1:0] cf, ct;
	logic signed [DW-1:0] diff;
	logic [DW-1:0] mag;
	logic [2*DW-1:0] sq;
	logic [RT_W+1:0] rem_sh, trial;
	logic [ACC_W-1:0] sum_nx;
	logic [SUM_W-1:0] sum_sat;
	logic [TOT_W-1:0] total;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	assign nfrom = dir_q ? count_b_q : count_a_q;
	assign nto = dir_q ? count_a_q : count_b_q;
	assign addr_a = dir_q ? j_q[AW-1:0] : i_q[AW-1:0];
	assign addr_b = dir_q ? i_q[AW-1:0] : j_q[AW-1:0];
	assign from_pt = dir_q ? rd_b_q : rd_a_q;
	assign to_pt = dir_q ? rd_a_q : rd_b_q;

	// One coordinate of the current pair is squared per cycle.
	always_comb begin
		case (k_q)
			2'd0: begin
				cf = from_pt[COORD_BITS-1:0];
				ct = to_pt[COORD_BITS-1:0];
			end
			2'd1: begin
				cf = from_pt[2*COORD_BITS-1:COORD_BITS];
				ct = to_pt[2*COORD_BITS-1:COORD_BITS];
			end
			default: begin
				cf = from_pt[3*COORD_BITS-1:2*COORD_BITS];
				ct = to_pt[3*COORD_BITS-1:2*COORD_BITS];
			end
		endcase
		diff = DW'(cf) - DW'(ct);
		mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
		sq = mag * mag;
	end

	assign rem_sh = {rem_q[RT_W-1:0], val_q[SQ_W-1:SQ_W-2]};
	assign trial = {root_q, 2'b01};
	assign sum_nx = ACC_W'(sum_q) + ACC_W'(add_q);
	assign sum_sat = (sum_nx > ACC_W'(SUM_LIMIT)) ? SUM_LIMIT : sum_nx[SUM_W-1:0];
	assign total = TOT_W'(sum_ab_q) + TOT_W'(sum_q);

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == OP_LOAD_A && count_a_q < CW'(MAX_POINTS)) begin
			mem_a[count_a_q[AW-1:0]] <= s_tdata[PW-1:0];
		end
		if (in_acc && s_tuser == OP_LOAD_B && count_b_q < CW'(MAX_POINTS)) begin
			mem_b[count_b_q[AW-1:0]] <= s_tdata[PW-1:0];
		end
		rd_a_q <= mem_a[addr_a];
		rd_b_q <= mem_b[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_q <= PENALTY_RESET;
		end else if (cfg_wr_en) begin
			penalty_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_a_q <= '0;
			count_b_q <= '0;
			dropped_q <= 1'b0;
			out_valid_q <= 1'b0;
			dir_q <= 1'b0;
		end else begin
			// The report state sets the valid itself when it launches a new result.
			if (out_valid_q && m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == OP_LOAD_A) begin
							if (count_a_q < CW'(MAX_POINTS)) begin
								count_a_q <= count_a_q + 1'b1;
							end else begin
								dropped_q <= 1'b1;
							end
						end else if (s_tuser == OP_LOAD_B) begin
							if (count_b_q < CW'(MAX_POINTS)) begin
								count_b_q <= count_b_q + 1'b1;
							end else begin
								dropped_q <= 1'b1;
							end
						end else if (s_tuser == OP_COMPUTE) begin
							dir_q <= 1'b0;
							i_q <= '0;
							sum_q <= '0;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					if (i_q >= nfrom) begin
						if (!dir_q) begin
							sum_ab_q <= sum_q;
							sum_q <= '0;
							i_q <= '0;
							dir_q <= 1'b1;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (nto == '0) begin
						add_q <= AD_W'(penalty_q);
						state_q <= ST_ACC;
					end else begin
						j_q <= '0;
						best_q <= '1;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					k_q <= 2'd0;
					acc_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q <= acc_q + SQ_W'(sq);
					k_q <= k_q + 1'b1;
					if (k_q == 2'd2) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					// The root is monotonic, so the minimum is taken on squares.
					if (acc_q < best_q) begin
						best_q <= acc_q;
					end
					j_q <= j_q + 1'b1;
					if (CW'(j_q + 1'b1) == nto) begin
						val_q <= (acc_q < best_q) ? acc_q : best_q;
						rem_q <= '0;
						root_q <= '0;
						sc_q <= '0;
						state_q <= ST_SQRT;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_SQRT: begin
					if (rem_sh >= trial) begin
						rem_q <= rem_sh - trial;
						root_q <= {root_q[RT_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						root_q <= {root_q[RT_W-2:0], 1'b0};
					end
					val_q <= {val_q[SQ_W-3:0], 2'b00};
					sc_q <= sc_q + 1'b1;
					if (sc_q == SC_W'(RT_W-1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (nto != '0) begin
						sum_q <= (ACC_W'(sum_q) + ACC_W'(root_q) > ACC_W'(SUM_LIMIT)) ?
							SUM_LIMIT : SUM_W'(ACC_W'(sum_q) + ACC_W'(root_q));
					end else begin
						sum_q <= sum_sat;
					end
					i_q <= i_q + 1'b1;
					state_q <= ST_START;
				end
				default: begin
					// Wait for the output register to free, then report and clear.
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q <= {dropped_q, CNT_OUT_W'(count_b_q), CNT_OUT_W'(count_a_q),
							total, sum_q, sum_ab_q};
						count_a_q <= '0;
						count_b_q <= '0;
						dropped_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Set counts never pass the capacity.
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_a_q <= CW'(MAX_POINTS) && count_b_q <= CW'(MAX_POINTS))
		else $error("point count exceeds capacity");

	// A reported total is always the sum of the two directed sums.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[90:60] == TOT_W'(m_tdata[29:0]) + TOT_W'(m_tdata[59:30])))
		else $error("total does not match directed sums");

	// A new result is launched only when the output register is free or drained.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !m_tready) |=> state_q == ST_DONE)
		else $error("result overwritten while waiting");
endmodule
`default_nettype wire
